>>> rtl/core/stps_pkg.sv
// ----------------------------------------------------------------------------
// stps_pkg: shared types and constants for the status token splitter
// Command codes passed from the front end to the back end, the command
// beat layout, and the status token prefixes recognized by the front end.
// ----------------------------------------------------------------------------
package stps_pkg;

   // command codes carried through the command queue
   localparam logic [1:0] CMD_NONE  = 2'd0;  // status-only result
   localparam logic [1:0] CMD_BYTE  = 2'd1;  // one payload byte
   localparam logic [1:0] CMD_FLUSH = 2'd2;  // percent, stored chars, byte
   localparam logic [1:0] CMD_RSVD  = 2'd3;  // unused

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       connected;
   } cmd_type;

   localparam logic [7:0] PCT_CHAR = 8'h25;

   // token prefixes; the first two connect the link, the last two drop it
   localparam int N_PFX   = 4;
   localparam int PFX_MAX = 11;
   localparam int PFX_STREAM_OPEN = 0;
   localparam int PFX_CONNECT     = 1;
   localparam int PFX_DISCONNECT  = 2;
   localparam int PFX_REBOOT      = 3;

   localparam int PFX_LEN [N_PFX] = '{11, 7, 10, 6};

   localparam logic [7:0] PFX_CHARS [N_PFX][PFX_MAX] = '{
      '{"S", "T", "R", "E", "A", "M", "_", "O", "P", "E", "N"},
      '{"C", "O", "N", "N", "E", "C", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "I", "S", "C", "O", "N", "N", "E", "C", "T", 8'h00},
      '{"R", "E", "B", "O", "O", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   // characters that may appear inside a token
   function automatic logic is_token_char(input logic [7:0] b);
      logic upper;
      logic digit;
      upper = (b >= 8'h41) && (b <= 8'h5A);
      digit = (b >= 8'h30) && (b <= 8'h39);
      return upper || digit || (b == 8'h2C) || (b == 8'h5F) || (b == 8'h2D);
   endfunction

endpackage

>>> rtl/core/stps_front.sv
// ----------------------------------------------------------------------------
// stps_front: byte classifier
// Tracks token state, buffers token characters into the back end's store,
// matches prefixes as characters arrive and issues one command per byte.
// ----------------------------------------------------------------------------
module stps_front #(
   parameter int TOKEN_CAPACITY = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 req_full,
   input  logic                                 q_full,
   output logic                                 q_push,
   output stps_pkg::cmd_type                    q_cmd,
   input  logic                                 flush_done,
   output logic                                 wr_en,
   output logic [$clog2(TOKEN_CAPACITY-1)-1:0]  wr_addr,
   output logic [7:0]                           wr_data,
   output logic [$clog2(TOKEN_CAPACITY)-1:0]    flush_len
);
   import stps_pkg::*;

   localparam int DEPTH  = TOKEN_CAPACITY - 1;
   localparam int LEN_W  = $clog2(TOKEN_CAPACITY);
   localparam int ADDR_W = $clog2(DEPTH);

   logic             inside_ff, inside_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [N_PFX-1:0] match_ff, match_in;
   logic             connected_ff, connected_in;
   logic             flush_pending_ff, flush_pending_in;

   logic             accept;
   logic [N_PFX-1:0] match_step;
   logic [N_PFX-1:0] hit;
   logic             hit_set;
   logic             hit_clr;

   // no new beat while a flush still reads the store
   assign req_full = q_full || flush_pending_ff;
   assign accept   = req_push && !req_full;
   assign flush_len = len_ff;

   // incremental prefix compare on the character being stored
   always_comb begin
      for (int p = 0; p < N_PFX; p++) begin
         match_step[p] = match_ff[p] &&
            ((len_ff >= LEN_W'(PFX_LEN[p])) || (req_rx_byte == PFX_CHARS[p][len_ff[3:0]]));
         hit[p] = match_ff[p] && (len_ff >= LEN_W'(PFX_LEN[p]));
      end
   end

   assign hit_set = hit[PFX_STREAM_OPEN] || hit[PFX_CONNECT];
   assign hit_clr = hit[PFX_DISCONNECT] || hit[PFX_REBOOT];

   // classify the accepted byte
   always_comb begin
      inside_in        = inside_ff;
      len_in           = len_ff;
      match_in         = match_ff;
      connected_in     = connected_ff;
      flush_pending_in = flush_pending_ff && !flush_done;
      wr_en            = 1'b0;
      wr_addr          = len_ff[ADDR_W-1:0];
      wr_data          = req_rx_byte;
      q_push           = accept;
      q_cmd.kind       = CMD_NONE;
      q_cmd.data       = 8'h00;
      if (accept) begin
         priority if (!inside_ff) begin
            if (req_rx_byte == PCT_CHAR) begin
               inside_in = 1'b1;
               len_in    = '0;
               match_in  = '1;
            end else begin
               q_cmd.kind = CMD_BYTE;
               q_cmd.data = req_rx_byte;
            end
         end else if (req_rx_byte == PCT_CHAR) begin
            // token closed: apply its status
            inside_in = 1'b0;
            if (hit_set) begin
               connected_in = 1'b1;
            end else if (hit_clr) begin
               connected_in = 1'b0;
            end
         end else if (is_token_char(req_rx_byte) && (len_ff < LEN_W'(DEPTH))) begin
            wr_en    = 1'b1;
            len_in   = len_ff + LEN_W'(1);
            match_in = match_step;
         end else begin
            // illegal byte or full store: replay the token as payload
            q_cmd.kind       = CMD_FLUSH;
            q_cmd.data       = req_rx_byte;
            inside_in        = 1'b0;
            flush_pending_in = 1'b1;
         end
      end
      q_cmd.connected = connected_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff        <= 1'b0;
         len_ff           <= '0;
         match_ff         <= '0;
         connected_ff     <= 1'b0;
         flush_pending_ff <= 1'b0;
      end else begin
         inside_ff        <= inside_in;
         len_ff           <= len_in;
         match_ff         <= match_in;
         connected_ff     <= connected_in;
         flush_pending_ff <= flush_pending_in;
      end
   end

endmodule

>>> rtl/core/stps_cmd_q.sv
// ----------------------------------------------------------------------------
// stps_cmd_q: two-entry command queue
// Decouples the byte classifier from the result sequencer.
// ----------------------------------------------------------------------------
module stps_cmd_q (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stps_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output stps_pkg::cmd_type head,
   output logic              empty
);
   import stps_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/stps_back.sv
// ----------------------------------------------------------------------------
// stps_back: result sequencer
// Holds the token character store and turns each command into result
// beats through a one-entry output register.
// ----------------------------------------------------------------------------
module stps_back #(
   parameter int TOKEN_CAPACITY = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_empty,
   input  stps_pkg::cmd_type                    q_head,
   output logic                                 q_pop,
   output logic                                 flush_done,
   input  logic [$clog2(TOKEN_CAPACITY)-1:0]    flush_len,
   input  logic                                 wr_en,
   input  logic [$clog2(TOKEN_CAPACITY-1)-1:0]  wr_addr,
   input  logic [7:0]                           wr_data,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [7:0]                           rsp_payload_byte,
   output logic                                 rsp_payload_valid,
   output logic                                 rsp_last_of_run,
   output logic                                 rsp_link_connected
);
   import stps_pkg::*;

   localparam int DEPTH  = TOKEN_CAPACITY - 1;
   localparam int LEN_W  = $clog2(TOKEN_CAPACITY);
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;
   localparam logic [1:0] ST_TAIL  = 2'd3;

   logic [7:0]       store [DEPTH];
   logic [7:0]       rd_data_ff;

   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_pv_ff, out_pv_in;
   logic             out_last_ff, out_last_in;
   logic             out_conn_ff, out_conn_in;

   logic             slot_free;
   logic             load;
   logic             idx_last;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign idx_last  = ((idx_ff + LEN_W'(1)) == flush_len);

   assign rsp_empty          = !out_valid_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_payload_valid  = out_pv_ff;
   assign rsp_last_of_run    = out_last_ff;
   assign rsp_link_connected = out_conn_ff;

   // token store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_data_ff <= store[idx_ff[ADDR_W-1:0]];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      load        = 1'b0;
      out_byte_in = out_byte_ff;
      out_pv_in   = out_pv_ff;
      out_last_in = out_last_ff;
      out_conn_in = q_head.connected;
      q_pop       = 1'b0;
      flush_done  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty && slot_free) begin
               load = 1'b1;
               unique case (q_head.kind)
                  CMD_BYTE: begin
                     out_byte_in = q_head.data;
                     out_pv_in   = 1'b1;
                     out_last_in = 1'b1;
                     q_pop       = 1'b1;
                  end
                  CMD_FLUSH: begin
                     out_byte_in = PCT_CHAR;
                     out_pv_in   = 1'b1;
                     out_last_in = 1'b0;
                     idx_in      = '0;
                     state_in    = (flush_len == '0) ? ST_TAIL : ST_FETCH;
                  end
                  default: begin
                     out_byte_in = 8'h00;
                     out_pv_in   = 1'b0;
                     out_last_in = 1'b1;
                     q_pop       = 1'b1;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               load        = 1'b1;
               out_byte_in = rd_data_ff;
               out_pv_in   = 1'b1;
               out_last_in = 1'b0;
               idx_in      = idx_ff + LEN_W'(1);
               state_in    = idx_last ? ST_TAIL : ST_FETCH;
            end
         end
         ST_TAIL: begin
            if (slot_free) begin
               load        = 1'b1;
               out_byte_in = q_head.data;
               out_pv_in   = 1'b1;
               out_last_in = 1'b1;
               q_pop       = 1'b1;
               flush_done  = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_valid_in = load || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= out_byte_in;
         out_pv_ff   <= out_pv_in;
         out_last_ff <= out_last_in;
         out_conn_ff <= out_conn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // a flush always works on a flush command at the queue head
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (!q_empty && (q_head.kind == CMD_FLUSH)))
      else $error("sequencer busy without a flush command");

   // the store is never written while it is being replayed
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !wr_en)
      else $error("store written during flush");

   // the read index stays below the flushed length
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FETCH) || (state_ff == ST_EMIT)) |-> (idx_ff < flush_len))
      else $error("flush index past stored length");

   // flushed length holds for the whole replay
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FETCH) || (state_ff == ST_EMIT)) |=> $stable(flush_len))
      else $error("flush length changed during replay");

endmodule

>>> rtl/core/status_token_payload_splitter.sv
// ----------------------------------------------------------------------------
// status_token_payload_splitter: UART status token / payload separator
// Pulls %TOKEN% status strings out of a received byte stream, tracks the
// link-connected flag, and passes everything else through as payload.
//
//   channel   ports                         beat
//   --------  ----------------------------  ---------------------------------
//   request   req_push / req_full           one received byte
//   response  rsp_empty / rsp_pop           one result; last_of_run ends a run
//
// Each request beat takes one command slot; a plain byte or token character
// puts its single result beat on the ports through the command queue and
// the output register. In a flush, each stored character is fetched from
// the token store through its registered read port, then emitted.
// Requests are held off (req_full) while a flush is queued or in progress.
// Reset is synchronous and clears all control state; the token store is not
// cleared. Either side may stall at any time without losing beats.
// ----------------------------------------------------------------------------
module status_token_payload_splitter #(
   parameter int TOKEN_CAPACITY = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_payload_valid,
   output logic       rsp_last_of_run,
   output logic       rsp_link_connected
);
   import stps_pkg::*;

   localparam int DEPTH  = TOKEN_CAPACITY - 1;
   localparam int LEN_W  = $clog2(TOKEN_CAPACITY);
   localparam int ADDR_W = $clog2(DEPTH);

   logic              q_push;
   cmd_type           q_cmd;
   logic              q_full;
   logic              q_pop;
   cmd_type           q_head;
   logic              q_empty;
   logic              flush_done;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [LEN_W-1:0]  flush_len;

   // front end: classify bytes
   stps_front #(.TOKEN_CAPACITY(TOKEN_CAPACITY)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd),
      .flush_done  (flush_done),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .flush_len   (flush_len)
   );

   // command queue between the two halves
   stps_cmd_q u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   // back end: emit result beats
   stps_back #(.TOKEN_CAPACITY(TOKEN_CAPACITY)) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .flush_done         (flush_done),
      .flush_len          (flush_len),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_link_connected (rsp_link_connected)
   );

endmodule
